// File: rtl/core/pcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pcd_pkg;

  // class code shown when the waiting stack holds nothing
  localparam logic [1:0] EMPTY_CLASS = 2'd3;
  // last server class visited by the arrival sequence
  localparam logic [1:0] LAST_CLASS  = 2'd2;
  localparam logic [1:0] FIRST_CLASS = 2'd0;

  // opcode field codes
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_ARRIVE = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       latch;     // capture the arriving item, clear drop flag
    logic       pop;       // move stack top into the server of cls
    logic       load_top;  // refresh cached top from the ram read port
    logic       push;      // place the arriving task if it belongs to cls
    logic       tick;      // count every busy server down by one
    logic [1:0] cls;       // class currently visited
  } dp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic pop_hit;         // top is of class cls and that server is idle
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/core/pcd_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pcd_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  waddr_i,
  input  wire logic [WIDTH-1:0]                            wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  raddr_i,
  output logic      [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/pcd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pcd_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  input  wire logic                opcode_i,
  input  wire pcd_pkg::dp_status_t stat_i,
  output pcd_pkg::dp_cmd_t         cmd_o,
  output logic                     busy,
  output logic                     done_o
);

  import pcd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_FETCH,
    ST_PUSH,
    ST_FINISH
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] cls_q, cls_d;
  logic       done_q;

  always_comb begin
    state_d   = state_q;
    cls_d     = cls_q;
    cmd_o     = '0;
    cmd_o.cls = cls_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          cls_d       = FIRST_CLASS;
          state_d     = (opcode_i == OP_ARRIVE) ? ST_POP : ST_FINISH;
        end
      end
      ST_POP: begin
        if (stat_i.pop_hit) begin
          cmd_o.pop = 1'b1;
          state_d   = ST_FETCH;
        end else begin
          state_d = ST_PUSH;
        end
      end
      ST_FETCH: begin
        cmd_o.load_top = 1'b1;
        state_d        = ST_PUSH;
      end
      ST_PUSH: begin
        cmd_o.push = 1'b1;
        if (cls_q == LAST_CLASS) begin
          state_d = ST_FINISH;
        end else begin
          cls_d   = cls_q + 2'd1;
          state_d = ST_POP;
        end
      end
      ST_FINISH: begin
        cmd_o.tick = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cls_q   <= FIRST_CLASS;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cls_q   <= cls_d;
      done_q  <= (state_q == ST_FINISH);
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

`default_nettype wire

// File: rtl/core/pcd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module pcd_datapath #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned LENGTH_BITS = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire pcd_pkg::dp_cmd_t cmd_i,
  output pcd_pkg::dp_status_t   stat_o,
  input  wire logic [1:0]       task_class_i,
  input  wire logic [7:0]       task_length_i,
  output logic      [7:0]       server0_left_o,
  output logic      [7:0]       server1_left_o,
  output logic      [7:0]       server2_left_o,
  output logic      [4:0]       waiting_count_o,
  output logic      [1:0]       top_class_o,
  output logic                  dropped_o
);

  import pcd_pkg::*;

  localparam int unsigned LB = LENGTH_BITS;
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned LW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned EW = (LB > 8) ? LB : 8;
  localparam int unsigned CW = (LW > 5) ? LW : 5;
  localparam int unsigned NS = 3;

  logic [LB-1:0] rem_q [NS];
  logic [LB-1:0] rem_d [NS];
  logic [LW-1:0] level_q, level_d;
  logic          lost_q, lost_d;
  logic [1:0]    top_cls_q, top_cls_d;
  logic [LB-1:0] top_len_q, top_len_d;
  logic [1:0]    in_cls_q;
  logic [LB-1:0] in_len_q;

  logic [EW-1:0] len_wide;
  logic [LB-1:0] in_len;
  logic          sel_idle;
  logic          full;
  logic          we;
  logic [LB+1:0] rd_data;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [LW-1:0] below_top;
  logic [EW-1:0] rem_wide [NS];
  logic [CW-1:0] level_wide;

  // task_length is fixed at 8 bits, the stored length follows LENGTH_BITS
  assign len_wide = EW'(task_length_i);
  assign in_len   = len_wide[LB-1:0];

  always_comb begin
    sel_idle = 1'b0;
    for (int k = 0; k < NS; k++) begin
      if (cmd_i.cls == 2'(k)) begin
        sel_idle = (rem_q[k] == '0);
      end
    end
  end

  assign full           = (level_q == LW'(STACK_DEPTH));
  assign stat_o.pop_hit = (level_q != '0) && (top_cls_q == cmd_i.cls) && sel_idle;

  // entry under the top becomes the new top after a pop
  assign below_top = level_q - LW'(2);
  assign raddr     = below_top[AW-1:0];
  assign waddr     = level_q[AW-1:0];

  always_comb begin
    rem_d     = rem_q;
    level_d   = level_q;
    lost_d    = lost_q;
    top_cls_d = top_cls_q;
    top_len_d = top_len_q;
    we        = 1'b0;
    if (cmd_i.latch) begin
      lost_d = 1'b0;
    end
    if (cmd_i.pop) begin
      for (int k = 0; k < NS; k++) begin
        if (cmd_i.cls == 2'(k)) begin
          rem_d[k] = top_len_q;
        end
      end
      level_d = level_q - LW'(1);
    end
    if (cmd_i.load_top) begin
      top_cls_d = rd_data[LB+1:LB];
      top_len_d = rd_data[LB-1:0];
    end
    if (cmd_i.push && (in_cls_q == cmd_i.cls)) begin
      if (sel_idle) begin
        for (int k = 0; k < NS; k++) begin
          if (cmd_i.cls == 2'(k)) begin
            rem_d[k] = in_len_q;
          end
        end
      end else if (!full) begin
        we        = 1'b1;
        top_cls_d = in_cls_q;
        top_len_d = in_len_q;
        level_d   = level_q + LW'(1);
      end else begin
        lost_d = 1'b1;
      end
    end
    if (cmd_i.tick) begin
      for (int k = 0; k < NS; k++) begin
        if (rem_q[k] != '0) begin
          rem_d[k] = rem_q[k] - LB'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) begin
        rem_q[k] <= '0;
      end
      level_q <= '0;
      lost_q  <= 1'b0;
    end else begin
      rem_q   <= rem_d;
      level_q <= level_d;
      lost_q  <= lost_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_cls_q <= top_cls_d;
    top_len_q <= top_len_d;
    if (cmd_i.latch) begin
      in_cls_q <= task_class_i;
      in_len_q <= in_len;
    end
  end

  pcd_ram #(
    .WIDTH (LB + 2),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({in_cls_q, in_len_q}),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      rem_wide[k] = EW'(rem_q[k]);
    end
  end

  assign level_wide      = CW'(level_q);
  assign server0_left_o  = rem_wide[0][7:0];
  assign server1_left_o  = rem_wide[1][7:0];
  assign server2_left_o  = rem_wide[2][7:0];
  assign waiting_count_o = level_wide[4:0];
  assign top_class_o     = (level_q != '0) ? top_cls_q : EMPTY_CLASS;
  assign dropped_o       = lost_q;

endmodule

`default_nettype wire

// File: rtl/core/priority_class_dispatcher_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake        payload
// command   in         start, busy      opcode_i, task_class_i, task_length_i
// result    out        done_o strobe    server0..2_left_o, waiting_count_o,
//                                       top_class_o, dropped_o
//
// a tick-only item passes only the finish state; an arrival has the class sequencer
// visit classes 0..2 one after another with a pop check, a top refetch after each pop
// (the stack ram read is registered) and a push check per class, then the finish state
// result fields are valid only in the done_o cycle; the next start may be taken
// in that same cycle, and the receiver cannot stall
// reset clears the servers, the stack level and the controller; stack entries
// are not cleared and only entries below the level are ever used

module priority_class_dispatcher_top #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned LENGTH_BITS = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       opcode_i,
  input  wire logic [1:0] task_class_i,
  input  wire logic [7:0] task_length_i,
  output logic            done_o,
  output logic      [7:0] server0_left_o,
  output logic      [7:0] server1_left_o,
  output logic      [7:0] server2_left_o,
  output logic      [4:0] waiting_count_o,
  output logic      [1:0] top_class_o,
  output logic            dropped_o
);

  import pcd_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t    cmd;
  dp_status_t stat;

  // sequencer: for arrivals pop check, optional top refetch, push check per class; then tick
  pcd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (opcode_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  // servers, waiting stack with cached top entry, result fields
  pcd_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .task_class_i    (task_class_i),
    .task_length_i   (task_length_i),
    .server0_left_o  (server0_left_o),
    .server1_left_o  (server1_left_o),
    .server2_left_o  (server2_left_o),
    .waiting_count_o (waiting_count_o),
    .top_class_o     (top_class_o),
    .dropped_o       (dropped_o)
  );

`ifndef ASSERT_OFF
  // a result strobe comes only once the sequencer is back at rest
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while busy");

  // an accepted command always occupies the sequencer
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted command left no work");

  // a pop is only issued when the datapath reports a matching idle server
  a_pop_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> stat.pop_hit) else $error("pop without matching top");

  // one result per command: the strobe is a single pulse and never repeats
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe repeated");
`endif

endmodule

`default_nettype wire
